>>> rtl/bhat_pkg.sv
`default_nettype none
package bhat_pkg;

  localparam int unsigned ENTRIES_DEF    = 128;
  localparam int unsigned ADDR_BITS_DEF  = 48;
  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned FIELD_ADDR_W   = 48;
  localparam logic [31:0] WARM_RST       = 32'd10;
  localparam logic [31:0] HOT_RST        = 32'd100;

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_TOUCH    = 2'd1;
  localparam logic [1:0] OP_PRUNE    = 2'd2;

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_PIN = 2'd2;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_WARM = 2'd1;
  localparam logic [1:0] REG_HOT  = 2'd2;

  localparam logic [1:0] TIER_COLD = 2'd0;
  localparam logic [1:0] TIER_WARM = 2'd1;
  localparam logic [1:0] TIER_HOT  = 2'd2;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_IGNORED   = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOMATCH   = 3'd4;
  localparam logic [2:0] ST_SKIPPED   = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [47:0] address;
    logic [47:0] region_size;
    logic [1:0]  start_tier;
    logic [30:0] hot_total;
    logic [30:0] all_total;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  entry_index;
    logic [1:0]  entry_tier;
    logic [31:0] entry_count;
    logic [7:0]  regions_tracked;
    logic [31:0] promotion_total;
  } rsp_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic capture;
    logic touch;
    logic prune;
    logic write;
    logic pin;
  } ctl_t;

endpackage
`default_nettype wire

>>> rtl/bhat_cell.sv
`default_nettype none
module bhat_cell #(
  parameter int unsigned ADDR_BITS  = bhat_pkg::ADDR_BITS_DEF,
  parameter int unsigned COUNT_BITS = bhat_pkg::COUNT_BITS_DEF,
  parameter int unsigned UW         = 8,
  parameter int unsigned INDEX      = 0
) (
  input  wire                   clk_i,
  input  bhat_pkg::req_t        cmd_i,
  input  bhat_pkg::ctl_t        ctl_i,
  input  wire [UW-1:0]          used_i,
  input  wire [31:0]            warm_thr_i,
  input  wire [31:0]            hot_thr_i,
  input  wire                   taken_i,
  output logic                  taken_o,
  output logic                  sel_o,
  output logic                  hit_o,
  output logic [1:0]            tier_o,
  output logic [COUNT_BITS-1:0] count_o,
  output logic                  promo_o
);

  localparam int unsigned AW = (ADDR_BITS < bhat_pkg::FIELD_ADDR_W) ?
                               ADDR_BITS : bhat_pkg::FIELD_ADDR_W;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic [UW-1:0] MY_IDX = UW'(INDEX);

  logic [AW-1:0]         base_q, len_q;
  logic [1:0]            tier_q, tier_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic                  hit_q, hit_d;
  logic                  valid, contains, promo, sel;
  logic [AW-1:0]         addr;
  logic [31:0]           inc_ext;

  assign addr     = cmd_i.address[AW-1:0];
  assign valid    = MY_IDX < used_i;
  assign contains = (addr >= base_q) && ((addr - base_q) < len_q);
  assign cnt_inc  = (cnt_q == CMAX) ? cnt_q : cnt_q + 1'b1;
  assign inc_ext  = 32'(cnt_inc);

  // lowest-index hit: a hit below claims the transaction, passed up the row
  assign sel     = hit_q && !taken_i;
  assign taken_o = taken_i || hit_q;

  always_comb begin
    hit_d = hit_q;
    if (ctl_i.capture) begin
      hit_d = valid && ((cmd_i.op == bhat_pkg::OP_REGISTER) ? (base_q == addr) : contains);
    end
  end

  always_comb begin
    tier_d = tier_q;
    cnt_d  = cnt_q;
    promo  = 1'b0;
    if (ctl_i.touch && sel) begin
      cnt_d = cnt_inc;
      if (ctl_i.pin) begin
        if (tier_q == bhat_pkg::TIER_COLD && inc_ext > warm_thr_i) begin
          tier_d = bhat_pkg::TIER_WARM;
          promo  = 1'b1;
        end else if (tier_q == bhat_pkg::TIER_WARM && inc_ext > hot_thr_i) begin
          tier_d = bhat_pkg::TIER_HOT;
          promo  = 1'b1;
        end
      end
    end else if (ctl_i.prune && valid) begin
      cnt_d = cnt_q >> 1;
      if (cnt_d == '0) begin
        tier_d = bhat_pkg::TIER_COLD;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
    if (ctl_i.write && used_i == MY_IDX) begin
      base_q <= addr;
      len_q  <= cmd_i.region_size[AW-1:0];
      tier_q <= (cmd_i.start_tier > bhat_pkg::TIER_HOT) ? bhat_pkg::TIER_HOT
                                                         : cmd_i.start_tier;
      cnt_q  <= '0;
    end else begin
      tier_q <= tier_d;
      cnt_q  <= cnt_d;
    end
  end

  assign sel_o   = sel;
  assign hit_o   = hit_q;
  assign tier_o  = sel ? tier_d : 2'd0;
  assign count_o = sel ? cnt_d : '0;
  assign promo_o = promo;

endmodule
`default_nettype wire

>>> rtl/block_access_heat_tiering_unit.sv
`default_nettype none
// Access-heat region table. Each region lives in its own cell, which holds
// base, length, tier and a saturating hit count. A transaction is accepted
// when start_i is high and busy_o is low; it then runs in order:
// the command is latched, every cell compares it in parallel and registers
// a hit flag, then the lowest-index hit is picked and the cells update
// (touch, append or a prune that halves all counts at once). The result
// is registered as the cells update and shows on result_o with valid_o high
// for exactly one cycle, and busy_o is low again in that same cycle.
// The receiver cannot stall: capture every valid_o. Configuration writes
// (cfg_we_i) are only legal while busy_o is low and no result is pending.
module block_access_heat_tiering_unit #(
  parameter int unsigned ENTRIES    = bhat_pkg::ENTRIES_DEF,
  parameter int unsigned ADDR_BITS  = bhat_pkg::ADDR_BITS_DEF,
  parameter int unsigned COUNT_BITS = bhat_pkg::COUNT_BITS_DEF
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            start_i,
  input  bhat_pkg::req_t req_i,
  output logic           busy_o,
  output logic           valid_o,
  output bhat_pkg::rsp_t result_o,
  input  wire            cfg_we_i,
  input  wire [1:0]      cfg_idx_i,
  input  wire [31:0]     cfg_data_i
);

  localparam int unsigned UW = $clog2(ENTRIES + 1);
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned AW = (ADDR_BITS < bhat_pkg::FIELD_ADDR_W) ?
                               ADDR_BITS : bhat_pkg::FIELD_ADDR_W;
  localparam logic [UW-1:0] FULL_CNT = UW'(ENTRIES);

  bhat_pkg::state_e state_q, state_d;
  bhat_pkg::req_t   cmd_q;
  bhat_pkg::ctl_t   ctl;
  bhat_pkg::rsp_t   rsp_q, rsp_d;
  logic             valid_q;
  logic [1:0]       mode_q;
  logic [31:0]      warm_q, hot_q, promo_q, promo_d;
  logic [UW-1:0]    used_q, used_d;

  logic [ENTRIES-1:0]    hit, sel, promo_v;
  logic [ENTRIES:0]      taken;
  logic [1:0]            tier_v  [ENTRIES];
  logic [COUNT_BITS-1:0] count_v [ENTRIES];
  logic [IW-1:0]         sel_idx;
  logic [1:0]            sel_tier;
  logic [COUNT_BITS-1:0] sel_cnt;
  logic                  any_hit, any_promo;
  logic                  pin, ignore, zero_addr, do_prune;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= bhat_pkg::MODE_OFF;
      warm_q <= bhat_pkg::WARM_RST;
      hot_q  <= bhat_pkg::HOT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bhat_pkg::REG_MODE: mode_q <= cfg_data_i[1:0];
        bhat_pkg::REG_WARM: warm_q <= cfg_data_i;
        bhat_pkg::REG_HOT:  hot_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    case (state_q)
      bhat_pkg::S_IDLE:  state_d = (start_i) ? bhat_pkg::S_MATCH : bhat_pkg::S_IDLE;
      bhat_pkg::S_MATCH: state_d = bhat_pkg::S_APPLY;
      bhat_pkg::S_APPLY: state_d = bhat_pkg::S_IDLE;
      default:           state_d = bhat_pkg::S_IDLE;
    endcase
  end

  assign pin       = (mode_q == bhat_pkg::MODE_PIN);
  assign zero_addr = (cmd_q.address[AW-1:0] == '0);
  assign do_prune  = 32'(cmd_q.hot_total) < 32'(cmd_q.all_total >> 1);

  always_comb begin
    case (cmd_q.op)
      bhat_pkg::OP_REGISTER,
      bhat_pkg::OP_TOUCH: ignore = (mode_q == bhat_pkg::MODE_OFF) || zero_addr;
      bhat_pkg::OP_PRUNE: ignore = !pin;
      default:            ignore = 1'b1;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.pin = pin;
    case (state_q)
      bhat_pkg::S_MATCH: ctl.capture = 1'b1;
      bhat_pkg::S_APPLY: begin
        ctl.touch = !ignore && cmd_q.op == bhat_pkg::OP_TOUCH;
        ctl.prune = !ignore && cmd_q.op == bhat_pkg::OP_PRUNE && do_prune;
        ctl.write = !ignore && cmd_q.op == bhat_pkg::OP_REGISTER && !any_hit &&
                    used_q < FULL_CNT;
      end
      default: ;
    endcase
  end

  // lowest-index hit: the claim ripples from cell 0 upward
  assign taken[0] = 1'b0;
  assign any_hit  = taken[ENTRIES];

  always_comb begin
    sel_idx   = '0;
    sel_tier  = '0;
    sel_cnt   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel[i]) sel_idx = sel_idx | IW'(i);
      sel_tier = sel_tier | tier_v[i];
      sel_cnt  = sel_cnt | count_v[i];
    end
  end
  assign any_promo = |promo_v;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    bhat_cell #(
      .ADDR_BITS (ADDR_BITS),
      .COUNT_BITS(COUNT_BITS),
      .UW        (UW),
      .INDEX     (g)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd_q),
      .ctl_i     (ctl),
      .used_i    (used_q),
      .warm_thr_i(warm_q),
      .hot_thr_i (hot_q),
      .taken_i   (taken[g]),
      .taken_o   (taken[g+1]),
      .sel_o     (sel[g]),
      .hit_o     (hit[g]),
      .tier_o    (tier_v[g]),
      .count_o   (count_v[g]),
      .promo_o   (promo_v[g])
    );
  end

  // result
  always_comb begin
    rsp_d   = '0;
    used_d  = used_q;
    promo_d = promo_q;
    if (ctl.touch && any_promo && promo_q != '1) begin
      promo_d = promo_q + 32'd1;
    end
    if (ctl.write) begin
      used_d = used_q + 1'b1;
    end
    if (ignore) begin
      rsp_d.status = bhat_pkg::ST_IGNORED;
    end else begin
      case (cmd_q.op)
        bhat_pkg::OP_REGISTER: begin
          if (any_hit) begin
            rsp_d.status      = bhat_pkg::ST_DUPLICATE;
            rsp_d.entry_index = 7'(sel_idx);
            rsp_d.entry_tier  = sel_tier;
            rsp_d.entry_count = 32'(sel_cnt);
          end else if (used_q >= FULL_CNT) begin
            rsp_d.status = bhat_pkg::ST_FULL;
          end else begin
            rsp_d.status      = bhat_pkg::ST_DONE;
            rsp_d.entry_index = 7'(used_q);
            rsp_d.entry_tier  = (cmd_q.start_tier > bhat_pkg::TIER_HOT) ?
                                bhat_pkg::TIER_HOT : cmd_q.start_tier;
          end
        end
        bhat_pkg::OP_TOUCH: begin
          if (any_hit) begin
            rsp_d.status      = bhat_pkg::ST_DONE;
            rsp_d.entry_index = 7'(sel_idx);
            rsp_d.entry_tier  = sel_tier;
            rsp_d.entry_count = 32'(sel_cnt);
          end else begin
            rsp_d.status = bhat_pkg::ST_NOMATCH;
          end
        end
        default: begin
          rsp_d.status = do_prune ? bhat_pkg::ST_DONE : bhat_pkg::ST_SKIPPED;
        end
      endcase
    end
    rsp_d.regions_tracked = 8'(used_d);
    rsp_d.promotion_total = promo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bhat_pkg::S_IDLE;
      valid_q <= 1'b0;
      used_q  <= '0;
      promo_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == bhat_pkg::S_APPLY);
      if (state_q == bhat_pkg::S_APPLY) begin
        used_q  <= used_d;
        promo_q <= promo_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bhat_pkg::S_IDLE && start_i) cmd_q <= req_i;
    if (state_q == bhat_pkg::S_APPLY) rsp_q <= rsp_d;
  end

  assign busy_o   = (state_q != bhat_pkg::S_IDLE);
  assign valid_o  = valid_q;
  assign result_o = rsp_q;

endmodule
`default_nettype wire

>>> rtl/bhat_checker.sv
`default_nettype none
module bhat_checker (
  input wire            clk_i,
  input wire            rst_ni,
  input wire            start_i,
  input wire            busy_o,
  input wire            valid_o,
  input bhat_pkg::rsp_t result_o
);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##3 valid_o)
    else $error("result not sampled three edges after accept");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("not busy after accept");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (result_o.status <= bhat_pkg::ST_SKIPPED))
    else $error("bad status code");

  a_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (result_o.status == bhat_pkg::ST_FULL ||
                 result_o.status == bhat_pkg::ST_IGNORED)) |->
    (result_o.entry_index == '0 && result_o.entry_count == '0))
    else $error("entry fields set without an entry");

endmodule

bind block_access_heat_tiering_unit bhat_checker u_bhat_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .valid_o (valid_o),
  .result_o(result_o)
);
`default_nettype wire

>>> tb/sv/tb_block_access_heat_tiering_unit.sv
`timescale 1ns / 1ps

import bhat_pkg::*;

// Tracks the region table alongside the block and checks every result.
class tier_scoreboard;
  logic [47:0] base_q [128];
  logic [47:0] len_q [128];
  logic [1:0]  tier_q [128];
  logic [31:0] hits_q [128];
  int unsigned used;
  logic [31:0] promos;
  logic [1:0]  mode;
  logic [31:0] warm_thr;
  logic [31:0] hot_thr;
  rsp_t        pending_q[$];
  int unsigned mismatches;

  function new();
    used = 0;
    promos = '0;
    mode = MODE_OFF;
    warm_thr = WARM_RST;
    hot_thr = HOT_RST;
    mismatches = 0;
  endfunction

  function void write_cfg(logic [1:0] idx, logic [31:0] data);
    case (idx)
      REG_MODE: mode = data[1:0];
      REG_WARM: warm_thr = data;
      REG_HOT:  hot_thr = data;
      default: ;
    endcase
  endfunction

  function rsp_t make_rsp(logic [2:0] st, int idx, bit has_entry);
    rsp_t r;
    r = '0;
    r.status = st;
    if (has_entry) begin
      r.entry_index = idx[6:0];
      r.entry_tier = tier_q[idx];
      r.entry_count = hits_q[idx];
    end
    r.regions_tracked = used[7:0];
    r.promotion_total = promos;
    return r;
  endfunction

  function void bump_promos();
    if (promos != 32'hFFFF_FFFF) promos++;
  endfunction

  // Apply one accepted transaction and queue the expected result.
  function void note_request(req_t rq);
    rsp_t r;
    int i;
    bit found;
    found = 0;
    r = make_rsp(ST_IGNORED, 0, 0);
    if (rq.op == OP_REGISTER) begin
      if (mode != MODE_OFF && rq.address != 0) begin
        for (i = 0; i < used; i++)
          if (!found && base_q[i] == rq.address) begin
            r = make_rsp(ST_DUPLICATE, i, 1);
            found = 1;
          end
        if (!found) begin
          if (used >= 128) r = make_rsp(ST_FULL, 0, 0);
          else begin
            base_q[used] = rq.address;
            len_q[used] = rq.region_size;
            tier_q[used] = (rq.start_tier > TIER_HOT) ? TIER_HOT : rq.start_tier;
            hits_q[used] = '0;
            used++;
            r = make_rsp(ST_DONE, used - 1, 1);
          end
        end
      end
    end else if (rq.op == OP_TOUCH) begin
      if (mode != MODE_OFF && rq.address != 0) begin
        r = make_rsp(ST_NOMATCH, 0, 0);
        for (i = 0; i < used; i++)
          if (!found && rq.address >= base_q[i] && rq.address - base_q[i] < len_q[i]) begin
            found = 1;
            if (hits_q[i] != 32'hFFFF_FFFF) hits_q[i]++;
            if (mode == MODE_PIN) begin
              if (tier_q[i] == TIER_COLD && hits_q[i] > warm_thr) begin
                tier_q[i] = TIER_WARM;
                bump_promos();
              end else if (tier_q[i] == TIER_WARM && hits_q[i] > hot_thr) begin
                tier_q[i] = TIER_HOT;
                bump_promos();
              end
            end
            r = make_rsp(ST_DONE, i, 1);
          end
      end
    end else if (rq.op == OP_PRUNE) begin
      if (mode == MODE_PIN) begin
        if (!(rq.hot_total < rq.all_total / 2)) r = make_rsp(ST_SKIPPED, 0, 0);
        else begin
          for (i = 0; i < used; i++) begin
            hits_q[i] = hits_q[i] >> 1;
            if (hits_q[i] == 0) tier_q[i] = TIER_COLD;
          end
          r = make_rsp(ST_DONE, 0, 0);
        end
      end
    end
    pending_q.push_back(r);
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  task check_result(rsp_t got);
    rsp_t w;
    if (pending_q.size() == 0) begin
      report("unexpected result", 64'(got.status), 64'd0);
      return;
    end
    w = pending_q.pop_front();
    if (got.status !== w.status) report("status", got.status, w.status);
    if (got.entry_index !== w.entry_index) report("entry_index", got.entry_index, w.entry_index);
    if (got.entry_tier !== w.entry_tier) report("entry_tier", got.entry_tier, w.entry_tier);
    if (got.entry_count !== w.entry_count) report("entry_count", got.entry_count, w.entry_count);
    if (got.regions_tracked !== w.regions_tracked)
      report("regions_tracked", got.regions_tracked, w.regions_tracked);
    if (got.promotion_total !== w.promotion_total)
      report("promotion_total", got.promotion_total, w.promotion_total);
  endtask
endclass

module tb_block_access_heat_tiering_unit;

  logic        clk;
  logic        rst_n;
  logic        start;
  req_t        req;
  logic        busy;
  logic        valid;
  rsp_t        result;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;

  tier_scoreboard sb;
  int          idle_pct;
  logic [47:0] known_bases[$];

  block_access_heat_tiering_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .req_i      (req),
    .busy_o     (busy),
    .valid_o    (valid),
    .result_o   (result),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // The receiver cannot stall, so every strobed result is checked.
  always @(posedge clk) begin
    if (rst_n && valid) sb.check_result(result);
  end

  // Safety net against a hung handshake.
  initial begin
    #20_000_000;
    $display("tb_block_access_heat_tiering_unit: done, errors");
    $finish;
  end

  // Hold start high until a rising edge sees busy low; random gaps first.
  // The block stays busy after an accept, so the trailing wait costs nothing.
  task automatic send(req_t rq);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1'b1;
    req <= rq;
    do @(posedge clk); while (busy);
    sb.note_request(rq);
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every transaction has come back, plus a little slack.
  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_cfg(idx, data);
    cfg_we <= 1'b0;
  endtask

  function automatic req_t mk(logic [1:0] op, logic [47:0] a, logic [47:0] sz,
                              logic [1:0] t, logic [30:0] h, logic [30:0] al);
    req_t r;
    r.op = op;
    r.address = a;
    r.region_size = sz;
    r.start_tier = t;
    r.hot_total = h;
    r.all_total = al;
    return r;
  endfunction

  function automatic logic [47:0] rnd48();
    return 48'({$urandom(), $urandom()} >> 16);
  endfunction

  // Mostly touches that land inside registered regions, so counts climb,
  // tiers move and prunes have something to decay.
  function automatic req_t rand_req();
    req_t r;
    int k;
    k = $urandom_range(99);
    r = mk(2'($urandom_range(3)), rnd48(), rnd48(), 2'($urandom_range(3)),
           31'($urandom() >> 1), 31'($urandom() >> 1));
    if (k < 15) begin
      r.op = OP_REGISTER;
      r.region_size = 48'($urandom_range(1, 4096));
      if ($urandom_range(3) == 0 && known_bases.size() != 0)
        r.address = known_bases[$urandom_range(known_bases.size() - 1)];
      else known_bases.push_back(r.address);
    end else if (k < 85) begin
      r.op = OP_TOUCH;
      if (known_bases.size() != 0)
        r.address = known_bases[$urandom_range(known_bases.size() - 1)]
                    + 48'($urandom_range(0, 4200));
    end else if (k < 93) begin
      r.op = OP_PRUNE;
      r.hot_total = 31'($urandom_range(0, 300));
      r.all_total = 31'($urandom_range(0, 600));
    end
    return r;
  endfunction

  initial begin
    int n;
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_MODE;
    cfg_data = '0;
    idle_pct = 9;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // mode off: everything ignored
    send(mk(OP_REGISTER, 48'h1000, 48'h100, TIER_COLD, 0, 0));
    send(mk(OP_TOUCH, 48'h1000, 0, 0, 0, 0));
    send(mk(OP_PRUNE, 0, 0, 0, 0, 10));

    write_reg(REG_MODE, 32'(MODE_PIN));
    write_reg(REG_WARM, 32'd2);
    write_reg(REG_HOT, 32'd4);
    send(mk(OP_REGISTER, 48'h0, 48'h10, TIER_COLD, 0, 0));          // zero address
    send(mk(OP_REGISTER, 48'h1000, 48'h100, TIER_COLD, 0, 0));
    send(mk(OP_REGISTER, 48'h1000, 48'h10, TIER_WARM, 0, 0));       // duplicate
    send(mk(OP_REGISTER, 48'hFFFF_FFFF_FFF0, 48'hFFFF_FFFF_FFFF, 2'd3, 0, 0));
    send(mk(OP_REGISTER, 48'h5000, 48'h0, TIER_HOT, 0, 0));         // zero length
    send(mk(OP_TOUCH, 48'h5000, 0, 0, 0, 0));                       // no match
    send(mk(OP_TOUCH, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0));
    for (int i = 0; i < 7; i++) send(mk(OP_TOUCH, 48'h10FF, 0, 0, 0, 0));
    send(mk(OP_TOUCH, 48'h1100, 0, 0, 0, 0));                       // one past end
    send(mk(OP_PRUNE, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF));      // skipped
    send(mk(OP_PRUNE, 0, 0, 0, 0, 31'h7FFF_FFFF));
    send(mk(2'd3, 48'h1000, 0, 0, 0, 0));                           // unused op
    for (int i = 0; i < 4; i++) send(mk(OP_PRUNE, 0, 0, 0, 0, 2));
    write_reg(REG_MODE, 32'd3);                                     // acts as track
    send(mk(OP_TOUCH, 48'h1000, 0, 0, 0, 0));
    send(mk(OP_PRUNE, 0, 0, 0, 0, 2));

    // saturation: warm at zero, hot at max, then fill past capacity
    write_reg(REG_MODE, 32'(MODE_PIN));
    write_reg(REG_WARM, 32'd0);
    write_reg(REG_HOT, 32'hFFFF_FFFF);
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 9 : (phase == 1) ? 74 : 0;
      for (n = 0; n < 300; n++) begin
        if (n == 100) begin
          drain();
          write_reg(REG_MODE, 32'($urandom_range(1, 3)));
          write_reg(REG_WARM, 32'($urandom_range(0, 20)));
          write_reg(REG_HOT, 32'($urandom_range(0, 60)));
        end
        if (n == 250) write_reg(REG_MODE, (phase == 2) ? 32'(MODE_OFF) : 32'(MODE_PIN));
        send(rand_req());
      end
      // fill the table once to hit the full case
      if (phase == 0) begin
        write_reg(REG_MODE, 32'(MODE_PIN));
        for (n = 0; n < 135; n++) send(mk(OP_REGISTER, rnd48() | 48'h1, 48'h40,
                                         2'($urandom_range(3)), 0, 0));
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("tb_block_access_heat_tiering_unit: done, clean");
    end else begin
      $display("tb_block_access_heat_tiering_unit: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bhat_pkg.sv
rtl/bhat_cell.sv
rtl/block_access_heat_tiering_unit.sv
rtl/bhat_checker.sv
tb/sv/tb_block_access_heat_tiering_unit.sv
